>>> src/dwc_pkg.sv
`default_nettype none
package dwc_pkg;

   // Register map, index is paddr[4:2]
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_SEGMENT_SIZE      = 3'd0;
   localparam logic [2:0] REG_BASE_AND_HOP      = 3'd1;
   localparam logic [2:0] REG_FLOW_SCALE_ALPHA  = 3'd2;
   localparam logic [2:0] REG_FLOW_SCALE_BETA   = 3'd3;
   localparam logic [2:0] REG_FLOW_SCALE_RANGE  = 3'd4;
   localparam logic [2:0] REG_ADDITIVE_STEP     = 3'd5;
   localparam logic [2:0] REG_DECREASE_GAIN     = 3'd6;
   localparam logic [2:0] REG_MAX_DECREASE      = 3'd7;

   // Reset values of the registers
   localparam logic [15:0] RST_SEGMENT_SIZE     = 16'd4096;
   localparam logic [31:0] RST_BASE_AND_HOP     = 32'd25000;
   localparam logic [31:0] RST_FLOW_SCALE_ALPHA = 32'd100000;
   localparam logic [31:0] RST_FLOW_SCALE_BETA  = 32'd0;
   localparam logic [31:0] RST_FLOW_SCALE_RANGE = 32'd100000;
   localparam logic [15:0] RST_ADDITIVE_STEP    = 16'd256;
   localparam logic [15:0] RST_DECREASE_GAIN    = 16'd52429;
   localparam logic [15:0] RST_MAX_DECREASE     = 16'd32768;

   localparam logic [7:0]  TIMEOUT_RESET_LIMIT  = 8'd5;

   // Shared divide / root unit sizes
   localparam int NUM_W  = 80;
   localparam int DEN_W  = 41;
   localparam int REM_W  = 42;
   localparam int STEP_W = 7;

   typedef struct packed {
      logic [15:0] segment_size;
      logic [31:0] base_and_hop_delay;
      logic [31:0] flow_scale_alpha;
      logic [31:0] flow_scale_beta;
      logic [31:0] flow_scale_range;
      logic [15:0] additive_step;
      logic [15:0] decrease_gain;
      logic [15:0] max_decrease;
   } dwc_cfg_type;

   typedef struct packed {
      logic              start;
      logic              sqrt_mode;
      logic [STEP_W-1:0] steps;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } dwc_iter_cmd_type;

endpackage
`default_nettype wire

>>> src/dwc_csr.sv
`default_nettype none
module dwc_csr import dwc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output dwc_cfg_type                cfg
);

   dwc_cfg_type cfg_ff;
   logic        wr_en;
   logic [2:0]  idx;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_size       <= RST_SEGMENT_SIZE;
         cfg_ff.base_and_hop_delay <= RST_BASE_AND_HOP;
         cfg_ff.flow_scale_alpha   <= RST_FLOW_SCALE_ALPHA;
         cfg_ff.flow_scale_beta    <= RST_FLOW_SCALE_BETA;
         cfg_ff.flow_scale_range   <= RST_FLOW_SCALE_RANGE;
         cfg_ff.additive_step      <= RST_ADDITIVE_STEP;
         cfg_ff.decrease_gain      <= RST_DECREASE_GAIN;
         cfg_ff.max_decrease       <= RST_MAX_DECREASE;
      end else if (wr_en) begin
         case (idx)
            REG_SEGMENT_SIZE:     cfg_ff.segment_size       <= csr_pwdata[15:0];
            REG_BASE_AND_HOP:     cfg_ff.base_and_hop_delay <= csr_pwdata;
            REG_FLOW_SCALE_ALPHA: cfg_ff.flow_scale_alpha   <= csr_pwdata;
            REG_FLOW_SCALE_BETA:  cfg_ff.flow_scale_beta    <= csr_pwdata;
            REG_FLOW_SCALE_RANGE: cfg_ff.flow_scale_range   <= csr_pwdata;
            REG_ADDITIVE_STEP:    cfg_ff.additive_step      <= csr_pwdata[15:0];
            REG_DECREASE_GAIN:    cfg_ff.decrease_gain      <= csr_pwdata[15:0];
            REG_MAX_DECREASE:     cfg_ff.max_decrease       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_SEGMENT_SIZE:     csr_prdata = {16'd0, cfg_ff.segment_size};
         REG_BASE_AND_HOP:     csr_prdata = cfg_ff.base_and_hop_delay;
         REG_FLOW_SCALE_ALPHA: csr_prdata = cfg_ff.flow_scale_alpha;
         REG_FLOW_SCALE_BETA:  csr_prdata = cfg_ff.flow_scale_beta;
         REG_FLOW_SCALE_RANGE: csr_prdata = cfg_ff.flow_scale_range;
         REG_ADDITIVE_STEP:    csr_prdata = {16'd0, cfg_ff.additive_step};
         REG_DECREASE_GAIN:    csr_prdata = {16'd0, cfg_ff.decrease_gain};
         REG_MAX_DECREASE:     csr_prdata = {16'd0, cfg_ff.max_decrease};
         default:              csr_prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

>>> src/dwc_iter.sv
`default_nettype none
// Restoring divide and digit-by-digit square root on one compare/subtract.
// The numerator is left aligned; one quotient bit or root digit per cycle.
module dwc_iter import dwc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dwc_iter_cmd_type cmd,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              sqrt_ff;
   logic [NUM_W-1:0]  num_ff,  num_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [NUM_W-1:0]  quo_ff,  quo_in;
   logic [DEN_W-1:0]  den_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              take;

   // One step: shift in, trial subtract, keep or restore
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
         trial  = {quo_ff[REM_W-3:0], 2'b01};
         num_in = {num_ff[NUM_W-3:0], 2'b00};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         trial  = {1'b0, den_ff};
         num_in = {num_ff[NUM_W-2:0], 1'b0};
      end
      take   = rem_sh >= trial;
      rem_in = take ? rem_sh - trial : rem_sh;
      quo_in = {quo_ff[NUM_W-2:0], take};
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == STEP_W'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff  <= cmd.num;
         den_ff  <= cmd.den;
         sqrt_ff <= cmd.sqrt_mode;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> src/delay_based_window_control_unit.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/ready    now_time, rtt_meas, counters, window_in
// rsp_      out        rsp_valid/ready    window_out, status, did_decrease
// csr_      in         APB, pready high   eight registers at 4*i
//
// With no event an accepted beat goes straight to ST_FIN; a NACK or timeout
// goes there directly or through ST_MULW and ST_CUT. req_ready and rsp_valid
// rise together as the result is loaded. On the ACK path the shared divide /
// root unit runs 64, 32 and 48 steps, then may run 80 or 48 after a multiply.
// req_ready is high only while idle; a finished beat waits in the output
// register, and the next item may be taken meanwhile. Reset is synchronous.
module delay_based_window_control_unit import dwc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [31:0]           req_now_time,
   input  wire logic [31:0]           req_rtt_meas,
   input  wire logic [31:0]           req_nack_total,
   input  wire logic [31:0]           req_timeout_total,
   input  wire logic [31:0]           req_ack_total,
   input  wire logic [31:0]           req_window_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [31:0]                rsp_window_out,
   output logic                       rsp_status,
   output logic                       rsp_did_decrease,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DIV1_GO = 5'd1;
   localparam logic [4:0] ST_DIV1_WT = 5'd2;
   localparam logic [4:0] ST_SQ_GO   = 5'd3;
   localparam logic [4:0] ST_SQ_WT   = 5'd4;
   localparam logic [4:0] ST_DIV2_GO = 5'd5;
   localparam logic [4:0] ST_DIV2_WT = 5'd6;
   localparam logic [4:0] ST_TGT     = 5'd7;
   localparam logic [4:0] ST_DEC     = 5'd8;
   localparam logic [4:0] ST_MA1     = 5'd9;
   localparam logic [4:0] ST_MA2     = 5'd10;
   localparam logic [4:0] ST_MN1     = 5'd11;
   localparam logic [4:0] ST_MN2     = 5'd12;
   localparam logic [4:0] ST_DIV3_GO = 5'd13;
   localparam logic [4:0] ST_DIV3_WT = 5'd14;
   localparam logic [4:0] ST_MD1     = 5'd15;
   localparam logic [4:0] ST_DIV4_GO = 5'd16;
   localparam logic [4:0] ST_DIV4_WT = 5'd17;
   localparam logic [4:0] ST_MULW    = 5'd18;
   localparam logic [4:0] ST_CUT     = 5'd19;
   localparam logic [4:0] ST_FIN     = 5'd20;

   localparam logic [34:0] INC_CAP = 35'h200000000;

   dwc_cfg_type      cfg;
   dwc_iter_cmd_type cmd;
   logic             iter_done;
   logic [NUM_W-1:0] quotient;

   logic [4:0]  state_ff, state_in;

   // Architectural state
   logic [31:0] last_nack_ff, last_rto_ff, last_ack_ff;
   logic [31:0] srtt_ff, last_dec_ff;
   logic [7:0]  streak_ff;

   // Per-item holding registers
   logic [31:0] w_ff, win_ff, now_ff, rtt_ff, dack_ff;
   logic [15:0] mss_ff;
   logic        cut_ff, none_ff;
   logic [31:0] f_ff;
   logic [32:0] target_ff;
   logic [23:0] a_hi_ff;
   logic [55:0] lo_ff;
   logic [15:0] mdf_ff;
   logic [34:0] nw_ff;
   logic [65:0] mul_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_window_ff;
   logic        rsp_status_ff, rsp_dd_ff;

   // Accept-time decode
   logic        accept;
   logic [31:0] d_nack, d_rto, d_ack, since_cut, w_eff;
   logic [15:0] mss_eff;
   logic        can_cut;
   logic [34:0] srtt_seven;
   logic [31:0] srtt_in;
   logic [7:0]  streak_inc;
   logic        win_reset;

   // Datapath helpers
   logic [32:0] mul_a, mul_b;
   logic [16:0] fac_f1, fac_f2, fac;
   logic signed [42:0] f_sum;
   logic [32:0] diff_w;
   logic [NUM_W-1:0] prod80;
   logic [31:0] w_sat;
   logic        fin_go;

   dwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dwc_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .done     (iter_done),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Event decode and smoothing on the incoming beat
   always_comb begin
      d_nack     = req_nack_total - last_nack_ff;
      d_rto      = req_timeout_total - last_rto_ff;
      d_ack      = req_ack_total - last_ack_ff;
      since_cut  = req_now_time - last_dec_ff;
      can_cut    = since_cut >= srtt_ff;
      w_eff      = (req_window_in == 32'd0) ? 32'd1 : req_window_in;
      mss_eff    = (cfg.segment_size == 16'd0) ? 16'd1 : cfg.segment_size;
      srtt_seven = {srtt_ff, 3'b000} - {3'b000, srtt_ff};
      srtt_in    = (srtt_ff != 32'd0) ?
                   srtt_seven[34:3] + {3'b000, req_rtt_meas[31:3]} : req_rtt_meas;
      streak_inc = (streak_ff == 8'hFF) ? streak_ff : streak_ff + 8'd1;
      win_reset  = streak_inc >= TIMEOUT_RESET_LIMIT;
   end

   // Shared multiplier operands
   always_comb begin
      fac_f1 = 17'h10000 - {1'b0, mdf_ff};
      fac_f2 = 17'h10000 - {1'b0, cfg.max_decrease};
      fac    = (fac_f1 > fac_f2) ? fac_f1 : fac_f2;
      diff_w = {1'b0, rtt_ff} - target_ff;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MA1: begin
            mul_a = {17'd0, mss_ff};
            mul_b = {17'd0, mss_ff};
         end
         ST_MA2: begin
            mul_a = {1'b0, mul_ff[31:0]};
            mul_b = {17'd0, cfg.additive_step};
         end
         ST_MN1: begin
            mul_a = {9'd0, mul_ff[23:0]};
            mul_b = {1'b0, dack_ff};
         end
         ST_MN2: begin
            mul_a = {9'd0, a_hi_ff};
            mul_b = {1'b0, dack_ff};
         end
         ST_MD1: begin
            mul_a = {1'b0, diff_w[31:0]};
            mul_b = {17'd0, cfg.decrease_gain};
         end
         ST_MULW: begin
            mul_a = {1'b0, w_ff};
            mul_b = {16'd0, fac};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // Launch the shared divide / root unit
   always_comb begin
      prod80        = {mul_ff[55:0], 24'd0} + {24'd0, lo_ff};
      cmd           = '0;
      case (state_ff)
         ST_DIV1_GO: begin
            cmd.start = 1'b1;
            cmd.steps = STEP_W'(64);
            cmd.num   = {w_ff, 48'd0};
            cmd.den   = {25'd0, mss_ff};
         end
         ST_SQ_GO: begin
            cmd.start     = 1'b1;
            cmd.sqrt_mode = 1'b1;
            cmd.steps     = STEP_W'(32);
            cmd.num       = {quotient[63:0], 16'd0};
         end
         ST_DIV2_GO: begin
            cmd.start = 1'b1;
            cmd.steps = STEP_W'(48);
            cmd.num   = {cfg.flow_scale_alpha, 48'd0};
            cmd.den   = {9'd0, quotient[31:0]};
         end
         ST_DIV3_GO: begin
            cmd.start = 1'b1;
            cmd.steps = STEP_W'(80);
            cmd.num   = prod80;
            cmd.den   = {1'b0, w_ff, 8'd0};
         end
         ST_DIV4_GO: begin
            cmd.start = 1'b1;
            cmd.steps = STEP_W'(48);
            cmd.num   = {mul_ff[47:0], 32'd0};
            cmd.den   = {9'd0, rtt_ff};
         end
         default: ;
      endcase
   end

   // Flow term: quotient plus signed offset
   assign f_sum = $signed({2'b00, quotient[40:0]}) +
                  $signed({{11{cfg.flow_scale_beta[31]}}, cfg.flow_scale_beta});

   assign w_sat  = (nw_ff[34:32] != 3'd0) ? 32'hFFFF_FFFF : nw_ff[31:0];
   assign fin_go = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (d_nack != 32'd0) begin
                  state_in = can_cut ? ST_MULW : ST_FIN;
               end else if (d_rto != 32'd0) begin
                  state_in = (!win_reset && can_cut) ? ST_MULW : ST_FIN;
               end else if (d_ack != 32'd0) begin
                  state_in = ST_DIV1_GO;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV1_GO: state_in = ST_DIV1_WT;
         ST_DIV1_WT: state_in = iter_done ? ST_SQ_GO : ST_DIV1_WT;
         ST_SQ_GO:   state_in = ST_SQ_WT;
         ST_SQ_WT:   state_in = iter_done ? ST_DIV2_GO : ST_SQ_WT;
         ST_DIV2_GO: state_in = ST_DIV2_WT;
         ST_DIV2_WT: state_in = iter_done ? ST_TGT : ST_DIV2_WT;
         ST_TGT:     state_in = ST_DEC;
         ST_DEC: begin
            if ({1'b0, rtt_ff} < target_ff) begin
               state_in = ST_MA1;
            end else if (!cut_ff) begin
               state_in = ST_FIN;
            end else if (rtt_ff == 32'd0) begin
               state_in = ST_MULW;
            end else begin
               state_in = ST_MD1;
            end
         end
         ST_MA1:     state_in = ST_MA2;
         ST_MA2:     state_in = ST_MN1;
         ST_MN1:     state_in = ST_MN2;
         ST_MN2:     state_in = ST_DIV3_GO;
         ST_DIV3_GO: state_in = ST_DIV3_WT;
         ST_DIV3_WT: state_in = iter_done ? ST_FIN : ST_DIV3_WT;
         ST_MD1:     state_in = ST_DIV4_GO;
         ST_DIV4_GO: state_in = ST_DIV4_WT;
         ST_DIV4_WT: state_in = iter_done ? ST_MULW : ST_DIV4_WT;
         ST_MULW:    state_in = ST_CUT;
         ST_CUT:     state_in = ST_FIN;
         ST_FIN:     state_in = fin_go ? ST_IDLE : ST_FIN;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_nack_ff <= '0;
         last_rto_ff  <= '0;
         last_ack_ff  <= '0;
         srtt_ff      <= '0;
         last_dec_ff  <= '0;
         streak_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            last_nack_ff <= req_nack_total;
            last_rto_ff  <= req_timeout_total;
            last_ack_ff  <= req_ack_total;
            srtt_ff      <= srtt_in;
            if (d_nack != 32'd0) begin
               streak_ff <= '0;
            end else if (d_rto != 32'd0) begin
               streak_ff <= streak_inc;
            end else if (d_ack != 32'd0) begin
               streak_ff <= '0;
            end
         end
         if (state_ff == ST_FIN && fin_go) begin
            if (!none_ff && (w_sat < win_ff)) begin
               last_dec_ff <= now_ff;
            end
         end
      end
   end

   // Per-item datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               w_ff    <= w_eff;
               win_ff  <= req_window_in;
               now_ff  <= req_now_time;
               rtt_ff  <= req_rtt_meas;
               dack_ff <= d_ack;
               mss_ff  <= mss_eff;
               cut_ff  <= can_cut;
               mdf_ff  <= 16'hFFFF;
               none_ff <= (d_nack == 32'd0 && d_rto == 32'd0 && d_ack == 32'd0);
               if (d_nack == 32'd0 && d_rto != 32'd0 && win_reset) begin
                  nw_ff <= {19'd0, mss_eff};
               end else if (d_nack == 32'd0 && d_rto == 32'd0 && d_ack == 32'd0) begin
                  nw_ff <= {3'd0, req_window_in};
               end else begin
                  nw_ff <= {3'd0, w_eff};
               end
            end
         end
         // Clamp the flow term to 0..range
         ST_DIV2_WT: begin
            if (f_sum < 0) begin
               f_ff <= '0;
            end else if (f_sum > $signed({11'd0, cfg.flow_scale_range})) begin
               f_ff <= cfg.flow_scale_range;
            end else begin
               f_ff <= f_sum[31:0];
            end
         end
         ST_TGT: target_ff <= {1'b0, cfg.base_and_hop_delay} + {1'b0, f_ff};
         ST_DEC: mdf_ff <= '0;
         ST_MN1: a_hi_ff <= mul_ff[47:24];
         ST_MN2: lo_ff <= mul_ff[55:0];
         // Additive increase, capped
         ST_DIV3_WT: begin
            if (iter_done) begin
               if (quotient > {45'd0, INC_CAP}) begin
                  nw_ff <= {3'd0, w_ff} + INC_CAP;
               end else begin
                  nw_ff <= {3'd0, w_ff} + quotient[34:0];
               end
            end
         end
         ST_DIV4_WT: begin
            if (iter_done) begin
               mdf_ff <= quotient[15:0];
            end
         end
         ST_CUT: nw_ff <= {2'd0, mul_ff[48:16]};
         default: ;
      endcase
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && fin_go) begin
         rsp_window_ff <= w_sat;
         rsp_status_ff <= none_ff;
         rsp_dd_ff     <= !none_ff && (w_sat < win_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_out   = rsp_window_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_did_decrease = rsp_dd_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_no_event_no_decrease: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_dd_ff)
      else $error("no-event beat flagged a decrease");

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      iter_done |-> (state_ff == ST_DIV1_WT || state_ff == ST_SQ_WT ||
                     state_ff == ST_DIV2_WT || state_ff == ST_DIV3_WT ||
                     state_ff == ST_DIV4_WT))
      else $error("divide unit finished outside a wait state");

endmodule
`default_nettype wire
